>>> design/hgpl_pkg.sv
// ----------------------------------------------------------------------------
// Hydraulic geometry power law: shared package
// Widths, pipeline depths and the constant factors of the fractional
// antilog used by the power law pipeline.
// ----------------------------------------------------------------------------
package hgpl_pkg;

    localparam int MAG_W       = 32;
    localparam int COEF_W      = 24;
    localparam int EXPO_W      = 18;
    localparam int FRAC_W      = 16;
    localparam int LOG_W       = 22;
    localparam int LOG_INT_W   = LOG_W - FRAC_W;
    localparam int P_W         = LOG_W + EXPO_W + 1;
    localparam int IP_W        = P_W - 32;
    localparam int ACC_W       = 31;
    localparam int PROD_W      = COEF_W + ACC_W;
    localparam int RES_W       = 32;
    localparam int DW_W        = 2 * RES_W;

    localparam int LOG_STEPS   = 16;
    localparam int LOG_LAT     = LOG_STEPS + 1;
    localparam int EXP_STEPS   = 16;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_LAT     = DIV_STEPS + 1;
    localparam int PIPE_DEPTH  = 1 + LOG_LAT + 1 + EXP_STEPS + 3 + DIV_LAT;

    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 104;
    localparam int M_TUSER_W   = 2;

    localparam logic [LOG_INT_W-1:0] LOG_OFFSET = LOG_INT_W'(12);
    localparam logic [1:0]           SHAPE_EXP  = 2'd2;
    localparam logic [RES_W-1:0]     RES_MAX    = '1;
    localparam logic [ACC_W-1:0]     ACC_ONE    = ACC_W'(1) << 30;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] v;
        r = '0;
        b = 64'd1 << 62;
        v = x;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Factor 2^(2^-k) in Q1.30, formed by k repeated square roots of two.
    function automatic logic [ACC_W-1:0] exp2_factor(input int k);
        logic [63:0] r;
        r = 64'd2 << 30;
        for (int j = 1; j <= EXP_STEPS; j++) begin
            if (j <= k) begin
                r = isqrt64(r << 30);
            end
        end
        return r[ACC_W-1:0];
    endfunction

endpackage

>>> design/hgpl_log.sv
// ----------------------------------------------------------------------------
// Hydraulic geometry power law: base-two logarithm pipeline
// Normalizes the magnitude, then forms one fraction bit per stage by
// repeated squaring of the mantissa.
// ----------------------------------------------------------------------------
module hgpl_log (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic [hgpl_pkg::MAG_W-1:0]             mag,
    output logic signed [hgpl_pkg::LOG_W-1:0]      log_val,
    output logic                                   is_zero
);

    localparam int STEPS = hgpl_pkg::LOG_STEPS;

    logic [4:0]                      msb;
    logic [hgpl_pkg::MAG_W-1:0]      norm;
    logic [4:0]                      e_reg    [STEPS+1];
    logic [hgpl_pkg::MAG_W-1:0]      m_reg    [STEPS+1];
    logic [hgpl_pkg::FRAC_W-1:0]     frac_reg [STEPS+1];
    logic                            zero_reg [STEPS+1];
    logic [hgpl_pkg::LOG_INT_W-1:0]  int_part;

    always_comb begin
        msb = '0;
        for (int i = 0; i < hgpl_pkg::MAG_W; i++) begin
            if (mag[i]) begin
                msb = 5'(i);
            end
        end
        norm = mag << (5'd31 - msb);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg[0]    <= msb;
            m_reg[0]    <= norm;
            frac_reg[0] <= '0;
            zero_reg[0] <= (mag == '0);
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [63:0] sq;
        logic [32:0] top;
        assign sq  = {32'b0, m_reg[k-1]} * {32'b0, m_reg[k-1]};
        assign top = sq[63:31];
        always_ff @(posedge aclk) begin
            if (en) begin
                e_reg[k]    <= e_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                if (top[32]) begin
                    m_reg[k]    <= top[32:1];
                    frac_reg[k] <= {frac_reg[k-1][hgpl_pkg::FRAC_W-2:0], 1'b1};
                end else begin
                    m_reg[k]    <= top[31:0];
                    frac_reg[k] <= {frac_reg[k-1][hgpl_pkg::FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    assign int_part = {1'b0, e_reg[STEPS]} - hgpl_pkg::LOG_OFFSET;
    assign log_val  = {int_part, frac_reg[STEPS]};
    assign is_zero  = zero_reg[STEPS];

endmodule

>>> design/hgpl_div.sv
// ----------------------------------------------------------------------------
// Hydraulic geometry power law: velocity divider pipeline
// Restoring division of the magnitude scaled by 2^36 by depth times width,
// one quotient bit per stage, with an overflow check at entry.
// ----------------------------------------------------------------------------
module hgpl_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [hgpl_pkg::DW_W-1:0]         dw,
    input  logic [hgpl_pkg::MAG_W-1:0]        mag,
    output logic [hgpl_pkg::RES_W-1:0]        quot,
    output logic                              over
);

    localparam int STEPS = hgpl_pkg::DIV_STEPS;
    localparam int W     = hgpl_pkg::DW_W;

    logic [W-1:0]                    start;
    logic [W-1:0]                    rem_reg  [STEPS+1];
    logic [W-1:0]                    dv_reg   [STEPS+1];
    logic [hgpl_pkg::RES_W-1:0]      q_reg    [STEPS+1];
    logic                            over_reg [STEPS+1];

    assign start = {28'b0, mag, 4'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= start;
            dv_reg[0]   <= dw;
            q_reg[0]    <= '0;
            over_reg[0] <= (dw <= start);
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [W:0] t;
        logic [W:0] diff;
        logic       ge;
        assign t    = {rem_reg[k-1], 1'b0};
        assign ge   = (t >= {1'b0, dv_reg[k-1]});
        assign diff = t - {1'b0, dv_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[W-1:0] : t[W-1:0];
                dv_reg[k]   <= dv_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][hgpl_pkg::RES_W-2:0], ge};
                over_reg[k] <= over_reg[k-1];
            end
        end
    end

    assign quot = q_reg[STEPS];
    assign over = over_reg[STEPS];

endmodule

>>> design/hydraulic_geometry_power_law_core.sv
// ----------------------------------------------------------------------------
// Hydraulic geometry power law core
// Depth, width and velocity of a river cell from its mean discharge.
// ----------------------------------------------------------------------------
// Each input transaction carries one cell: discharge, the two coefficients
// and two exponents on s_tdata, and the missing-discharge flag on s_tuser.
// Each cell yields exactly one output transaction with depth, width,
// velocity and the shape exponent on m_tdata and the velocity-undefined and
// saturation flags on m_tuser.
// The core is a 71-stage pipeline followed by an output register. One cell
// is accepted every cycle while s_tready is high. Most of the stages are
// the sixteen squaring stages of the logarithm, the sixteen multiply stages
// of the antilog and the thirty-two stages of the velocity divider.
// Reset clears all valid bits; no result is produced for cells in flight.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps advancing until its last stage is full; then s_tready
// falls and every stage holds until m_tready returns.
// ----------------------------------------------------------------------------
module hydraulic_geometry_power_law_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // discharge, depth_coef, depth_exponent, width_coef, width_exponent
    input  logic [hgpl_pkg::S_TDATA_W-1:0]      s_tdata,
    // discharge_missing
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mean_depth, mean_width, mean_velocity, shape_exponent
    output logic [hgpl_pkg::M_TDATA_W-1:0]      m_tdata,
    // velocity_undefined, result_saturated
    output logic [hgpl_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int DEPTH = hgpl_pkg::PIPE_DEPTH;
    localparam int LLAT  = hgpl_pkg::LOG_LAT;
    localparam int ESTEP = hgpl_pkg::EXP_STEPS;
    localparam int DLAT  = hgpl_pkg::DIV_LAT;

    typedef struct packed {
        logic                            miss;
        logic [hgpl_pkg::MAG_W-1:0]      mag;
        logic [hgpl_pkg::COEF_W-1:0]     dcoef;
        logic [hgpl_pkg::COEF_W-1:0]     wcoef;
        logic [hgpl_pkg::EXPO_W-1:0]     dexp;
        logic [hgpl_pkg::EXPO_W-1:0]     wexp;
    } hgpl_side_t;

    typedef struct packed {
        logic                            miss;
        logic                            undef;
        logic                            sat;
        logic [hgpl_pkg::RES_W-1:0]      d;
        logic [hgpl_pkg::RES_W-1:0]      w;
    } hgpl_tail_t;

    function automatic logic [hgpl_pkg::RES_W:0] scale_out(
        input logic [hgpl_pkg::PROD_W-1:0]     prod,
        input logic [hgpl_pkg::IP_W-1:0]       ip,
        input logic                            kill
    );
        logic signed [9:0]                 s;
        logic signed [9:0]                 ns;
        logic [hgpl_pkg::PROD_W+31:0]      wide;
        logic [hgpl_pkg::PROD_W-1:0]       sh;
        s  = $signed({ip[hgpl_pkg::IP_W-1], ip}) - 10'sd30;
        ns = -s;
        if (kill || prod == '0) begin
            return '0;
        end
        if (!s[9]) begin
            if (s >= 10'sd32) begin
                return {1'b1, hgpl_pkg::RES_MAX};
            end
            wide = {32'b0, prod} << s[4:0];
            if (wide[hgpl_pkg::PROD_W+31:32] != '0) begin
                return {1'b1, hgpl_pkg::RES_MAX};
            end
            return {1'b0, wide[31:0]};
        end
        if (ns >= 10'sd64) begin
            return '0;
        end
        sh = prod >> ns[5:0];
        if (sh[hgpl_pkg::PROD_W-1:32] != '0) begin
            return {1'b1, hgpl_pkg::RES_MAX};
        end
        return {1'b0, sh[31:0]};
    endfunction

    logic                                 v_reg [DEPTH];
    logic                                 pipe_en;
    logic                                 out_take;
    logic [hgpl_pkg::MAG_W-1:0]           raw;
    hgpl_side_t                           s0_reg;
    hgpl_side_t                           side_a_reg [LLAT];
    hgpl_side_t                           side_e_reg [ESTEP+1];
    logic signed [hgpl_pkg::LOG_W-1:0]    log_val;
    logic                                 log_zero;

    logic [hgpl_pkg::ACC_W-1:0]           acc_reg  [2][ESTEP+1];
    logic [hgpl_pkg::FRAC_W-1:0]          f_reg    [2][ESTEP+1];
    logic [hgpl_pkg::IP_W-1:0]            ip_reg   [2][ESTEP+1];
    logic                                 kill_reg [2][ESTEP+1];

    logic [hgpl_pkg::PROD_W-1:0]          prod_reg  [2];
    logic [hgpl_pkg::IP_W-1:0]            pip_reg   [2];
    logic                                 pkill_reg [2];
    logic                                 pmiss_reg;
    logic [hgpl_pkg::MAG_W-1:0]           pmag_reg;

    logic [hgpl_pkg::RES_W:0]             d_scaled;
    logic [hgpl_pkg::RES_W:0]             w_scaled;
    logic [hgpl_pkg::RES_W-1:0]           d_reg;
    logic [hgpl_pkg::RES_W-1:0]           w_reg;
    logic                                 sat_reg;
    logic                                 smiss_reg;
    logic [hgpl_pkg::MAG_W-1:0]           smag_reg;

    logic [hgpl_pkg::DW_W-1:0]            dw_reg;
    logic [hgpl_pkg::MAG_W-1:0]           dmag_reg;
    hgpl_tail_t                           dtail_reg;
    hgpl_tail_t                           tail_reg [DLAT];

    logic [hgpl_pkg::RES_W-1:0]           quot;
    logic                                 over;
    hgpl_tail_t                           tail;
    logic [hgpl_pkg::RES_W-1:0]           vel;
    logic                                 sat_all;

    logic                                 m_tvalid_reg;
    logic                                 m_tvalid_next;
    logic [hgpl_pkg::M_TDATA_W-1:0]       m_tdata_reg;
    logic [hgpl_pkg::M_TDATA_W-1:0]       m_tdata_next;
    logic [hgpl_pkg::M_TUSER_W-1:0]       m_tuser_reg;
    logic [hgpl_pkg::M_TUSER_W-1:0]       m_tuser_next;

    assign out_take = !m_tvalid_reg || m_tready;
    assign pipe_en  = !v_reg[DEPTH-1] || out_take;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (pipe_en) begin
            v_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign raw = s_tdata[31:0];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_reg.miss  <= s_tuser;
            s0_reg.mag   <= raw[31] ? (32'd0 - raw) : raw;
            s0_reg.dcoef <= s_tdata[55:32];
            s0_reg.dexp  <= s_tdata[73:56];
            s0_reg.wcoef <= s_tdata[97:74];
            s0_reg.wexp  <= s_tdata[115:98];
            side_a_reg[0] <= s0_reg;
            for (int i = 1; i < LLAT; i++) begin
                side_a_reg[i] <= side_a_reg[i-1];
            end
        end
    end

    hgpl_log u_log (
        .aclk    (aclk),
        .en      (pipe_en),
        .mag     (s0_reg.mag),
        .log_val (log_val),
        .is_zero (log_zero)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_e_reg[0] <= side_a_reg[LLAT-1];
            for (int i = 1; i <= ESTEP; i++) begin
                side_e_reg[i] <= side_e_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [hgpl_pkg::EXPO_W-1:0]      ex;
        logic signed [hgpl_pkg::P_W-1:0]  p;
        assign ex = (l == 0) ? side_a_reg[LLAT-1].dexp : side_a_reg[LLAT-1].wexp;
        assign p  = log_val * $signed({1'b0, ex});

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                acc_reg[l][0] <= hgpl_pkg::ACC_ONE;
                if (log_zero) begin
                    ip_reg[l][0]   <= '0;
                    f_reg[l][0]    <= '0;
                    kill_reg[l][0] <= (ex != '0);
                end else begin
                    ip_reg[l][0]   <= p[hgpl_pkg::P_W-1:32];
                    f_reg[l][0]    <= p[31:16];
                    kill_reg[l][0] <= 1'b0;
                end
            end
        end

        for (genvar k = 1; k <= ESTEP; k++) begin : g_exp
            localparam logic [hgpl_pkg::ACC_W-1:0] FACT = hgpl_pkg::exp2_factor(k);
            logic [2*hgpl_pkg::ACC_W-1:0] mul;
            assign mul = {31'b0, acc_reg[l][k-1]} * {31'b0, FACT};
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    acc_reg[l][k]  <= f_reg[l][k-1][ESTEP-k] ? mul[60:30]
                                                             : acc_reg[l][k-1];
                    f_reg[l][k]    <= f_reg[l][k-1];
                    ip_reg[l][k]   <= ip_reg[l][k-1];
                    kill_reg[l][k] <= kill_reg[l][k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                prod_reg[l]  <= ((l == 0) ? {31'b0, side_e_reg[ESTEP].dcoef}
                                          : {31'b0, side_e_reg[ESTEP].wcoef})
                                * {24'b0, acc_reg[l][ESTEP]};
                pip_reg[l]   <= ip_reg[l][ESTEP];
                pkill_reg[l] <= kill_reg[l][ESTEP];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pmiss_reg <= side_e_reg[ESTEP].miss;
            pmag_reg  <= side_e_reg[ESTEP].mag;
        end
    end

    assign d_scaled = scale_out(prod_reg[0], pip_reg[0], pkill_reg[0]);
    assign w_scaled = scale_out(prod_reg[1], pip_reg[1], pkill_reg[1]);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d_reg     <= d_scaled[hgpl_pkg::RES_W-1:0];
            w_reg     <= w_scaled[hgpl_pkg::RES_W-1:0];
            sat_reg   <= d_scaled[hgpl_pkg::RES_W] | w_scaled[hgpl_pkg::RES_W];
            smiss_reg <= pmiss_reg;
            smag_reg  <= pmag_reg;

            dw_reg          <= {32'b0, d_reg} * {32'b0, w_reg};
            dmag_reg        <= smag_reg;
            dtail_reg.miss  <= smiss_reg;
            dtail_reg.undef <= (d_reg == '0) || (w_reg == '0);
            dtail_reg.sat   <= sat_reg;
            dtail_reg.d     <= d_reg;
            dtail_reg.w     <= w_reg;

            tail_reg[0] <= dtail_reg;
            for (int i = 1; i < DLAT; i++) begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    hgpl_div u_div (
        .aclk (aclk),
        .en   (pipe_en),
        .dw   (dw_reg),
        .mag  (dmag_reg),
        .quot (quot),
        .over (over)
    );

    assign tail    = tail_reg[DLAT-1];
    assign vel     = tail.undef ? '0 : (over ? hgpl_pkg::RES_MAX : quot);
    assign sat_all = tail.sat | (!tail.undef & over);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_take) begin
            m_tvalid_next = v_reg[DEPTH-1];
            if (tail.miss) begin
                m_tdata_next = {6'b0, hgpl_pkg::SHAPE_EXP, 96'b0};
                m_tuser_next = '0;
            end else begin
                m_tdata_next = {6'b0, hgpl_pkg::SHAPE_EXP, vel, tail.w, tail.d};
                m_tuser_next = {sat_all, tail.undef};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && v_reg[DEPTH-1]) |=> m_tvalid)
        else $error("A finished transaction did not reach the output register.");

    a_undef_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[95:64] == '0 && (m_tdata[31:0] == '0 || m_tdata[63:32] == '0)))
        else $error("Undefined velocity reported with nonzero depth and width.");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && v_reg[DEPTH-1]))
        else $error("Input stalled while the pipeline could advance.");
`endif

endmodule

>>> test/hydraulic_geometry_power_law_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hydraulic geometry power law core testbench
// Streams river cells into the core with random gaps and random output
// stalls, predicts or looks up depth, width, velocity and flags for every
// cell, and compares each output with the oldest pending expectation.
// ----------------------------------------------------------------------------
module hydraulic_geometry_power_law_core_tb;

    typedef struct packed {
        logic [17:0] wexp;
        logic [23:0] wcoef;
        logic [17:0] dexp;
        logic [23:0] dcoef;
        logic [31:0] q;
    } cell_t;

    typedef struct packed {
        logic        sat;
        logic        undef;
        logic [1:0]  shape;
        logic [31:0] vel;
        logic [31:0] wid;
        logic [31:0] dep;
    } geom_t;

    typedef struct {
        cell_t c;
        logic  miss;
        logic  known;
        geom_t g;
    } row_t;

    localparam int N_RANDOM = 1200;
    localparam int WATCHDOG = 2000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    geom_t geom_pending[$];
    row_t  rows[$];
    int    errors = 0;
    int    n_cells = 0;
    int    n_in = 0;
    int    n_results = 0;
    int    idle_cycles = 0;
    int    sink_wait = 0;
    logic  stall_enable = 1'b1;
    logic  s_xfer_done = 1'b0;
    logic [63:0] sqrt2_pow[1:16];

    hydraulic_geometry_power_law_core uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r, b, v;
        r = '0;
        b = 64'd1 << 62;
        v = x;
        while (b > v && b != 0) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_of(input logic [31:0] mag);
        int e;
        logic [63:0] m;
        logic [15:0] f;
        e = 31;
        f = '0;
        while (e > 0 && mag[e] == 1'b0) e--;
        m = 64'(mag) << (31 - e);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= 64'h1_0000_0000) begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (longint'(e) - 12) * 65536 + longint'(f);
    endfunction

    function automatic logic [63:0] antilog_frac(input logic [15:0] f);
        logic [63:0] acc;
        acc = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            if (f[16-k]) acc = (acc * sqrt2_pow[k]) >> 30;
        end
        return acc;
    endfunction

    function automatic logic [31:0] scaled_power(input logic [31:0] mag,
            input logic [23:0] coef, input logic [17:0] ex, inout logic sat);
        longint ip, s, p;
        logic [63:0] acc, prod, biased;
        if (mag == 0) begin
            if (ex != 0) return 32'd0;
            ip = 0;
            acc = 64'd1 << 30;
        end else begin
            p = log2_of(mag) * longint'(ex);
            biased = 64'(p + 64'sd64 * 64'sd4294967296);
            ip = longint'(biased >> 32) - 64;
            acc = antilog_frac(biased[31:16]);
        end
        prod = 64'(coef) * acc;
        if (prod == 0) return 32'd0;
        s = ip - 30;
        if (s >= 0) begin
            if (s >= 32 || prod > (64'hFFFF_FFFF >> s)) begin
                sat = 1'b1;
                return hgpl_pkg::RES_MAX;
            end
            return 32'(prod << s);
        end
        if (-s >= 64) return 32'd0;
        prod = prod >> (-s);
        if (prod > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return hgpl_pkg::RES_MAX;
        end
        return prod[31:0];
    endfunction

    function automatic logic [31:0] flow_velocity(input logic [31:0] mag,
            input logic [63:0] dw, inout logic sat);
        logic [63:0] rem, q, bitv, carry;
        if (dw <= 64'(mag) * 16) begin
            sat = 1'b1;
            return hgpl_pkg::RES_MAX;
        end
        rem = '0;
        q = '0;
        for (int i = 67; i >= 0; i--) begin
            bitv = (i >= 36) ? 64'((mag >> (i - 36)) & 1) : 64'd0;
            carry = rem >> 63;
            rem = (rem << 1) | bitv;
            if (carry != 0 || rem >= dw) begin
                rem = rem - dw;
                q = (q << 1) | 1;
            end else begin
                q = q << 1;
            end
        end
        return q[31:0];
    endfunction

    function automatic geom_t predict_geometry(input cell_t c, input logic miss);
        geom_t g;
        logic [31:0] mag;
        logic [63:0] dw;
        logic sat;
        g = '0;
        g.shape = hgpl_pkg::SHAPE_EXP;
        if (miss) return g;
        sat = 1'b0;
        mag = c.q[31] ? 32'(-c.q) : c.q;
        g.dep = scaled_power(mag, c.dcoef, c.dexp, sat);
        g.wid = scaled_power(mag, c.wcoef, c.wexp, sat);
        dw = 64'(g.dep) * 64'(g.wid);
        if (dw == 0) g.undef = 1'b1;
        else g.vel = flow_velocity(mag, dw, sat);
        g.sat = sat;
        return g;
    endfunction

    function automatic row_t cell_row(input logic [31:0] q, input logic [23:0] dc,
            input logic [17:0] de, input logic [23:0] wc, input logic [17:0] we,
            input logic miss);
        row_t r;
        r.c = '{wexp: we, wcoef: wc, dexp: de, dcoef: dc, q: q};
        r.miss = miss;
        r.known = 1'b0;
        r.g = '0;
        return r;
    endfunction

    function automatic row_t known_row(input row_t r, input logic [31:0] d,
            input logic [31:0] w, input logic [31:0] v, input logic u, input logic s);
        r.known = 1'b1;
        r.g = '{sat: s, undef: u, shape: hgpl_pkg::SHAPE_EXP, vel: v, wid: w, dep: d};
        return r;
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        c = bits[115:0];
        case ($urandom_range(0, 5))
            0: c.q = $urandom_range(0, 1) ? 32'h8000_0000 : $urandom_range(0, 4);
            1: c.q = $urandom_range(0, 8191) - 4096;
            2: c.q = 32'($signed(c.q) >>> $urandom_range(0, 31));
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0) begin
            c.dexp = 18'($urandom_range(0, 98304));
            c.wexp = 18'($urandom_range(0, 98304));
        end
        if ($urandom_range(0, 7) == 0) c.dcoef = '0;
        if ($urandom_range(0, 7) == 0) c.wexp = '0;
        return c;
    endfunction

    task automatic send_cell(input cell_t c, input logic miss);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {4'b0, c};
        s_tuser <= miss;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_cells++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (n_in < rows.size() && rows[n_in].known)
                geom_pending.push_back(rows[n_in].g);
            else
                geom_pending.push_back(predict_geometry(cell_t'(s_tdata[115:0]), s_tuser));
            n_in++;
        end
    end

    always @(posedge aclk) begin
        geom_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[97:0]};
            n_results++;
            if (geom_pending.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
            end else begin
                want = geom_pending.pop_front();
                if (got.dep !== want.dep)
                    $display("%0t: depth expected %h actual %h", $time, want.dep, got.dep);
                if (got.wid !== want.wid)
                    $display("%0t: width expected %h actual %h", $time, want.wid, got.wid);
                if (got.vel !== want.vel)
                    $display("%0t: velocity expected %h actual %h", $time,
                             want.vel, got.vel);
                if (got.shape !== want.shape)
                    $display("%0t: shape expected %0d actual %0d", $time,
                             want.shape, got.shape);
                if (got.undef !== want.undef)
                    $display("%0t: undefined flag expected %b actual %b", $time,
                             want.undef, got.undef);
                if (got.sat !== want.sat)
                    $display("%0t: saturated flag expected %b actual %b", $time,
                             want.sat, got.sat);
                if (got !== want) errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = $urandom_range(0, 17);
        end else if (m_tvalid && m_tready) begin
            sink_wait = stall_enable ? $urandom_range(0, 17) : 0;
            m_tready <= (sink_wait == 0);
        end else if (sink_wait > 0) begin
            sink_wait = sink_wait - 1;
            m_tready <= (sink_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (s_xfer_done && geom_pending.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        row_t r;
        for (int k = 1; k <= 16; k++)
            sqrt2_pow[k] = (k == 1) ? root64(64'd2 << 60) : root64(sqrt2_pow[k-1] << 30);

        rows.push_back(known_row(cell_row(32'h7FFF_FFFF, '1, '1, '1, '1, 1'b1),
                                 0, 0, 0, 1'b0, 1'b0));
        rows.push_back(known_row(cell_row(32'h0, 24'h01_0000, 18'h1_0000, 24'h01_0000,
                                          18'h1_0000, 1'b0), 0, 0, 0, 1'b1, 1'b0));
        rows.push_back(known_row(cell_row(32'h0, 24'h01_0000, 18'h0, 24'h01_0000, 18'h0,
                                          1'b0), 32'h1_0000, 32'h1_0000, 0, 1'b0, 1'b0));
        rows.push_back(known_row(cell_row(32'h1000, 24'h01_0000, 18'h1_0000, 24'h0,
                                          18'h1_0000, 1'b0), 32'h1_0000, 0, 0, 1'b1, 1'b0));
        rows.push_back(cell_row(32'h8000_0000, '1, '1, '1, '1, 1'b0));
        rows.push_back(cell_row(32'h7FFF_FFFF, '1, '1, '1, '1, 1'b0));
        rows.push_back(cell_row(32'hFFFF_FFFF, 24'h00_0001, 18'h0, 24'h00_0001, 18'h0, 1'b0));
        rows.push_back(cell_row(32'h1, '1, '1, '1, '1, 1'b0));
        rows.push_back(cell_row(32'h1, 24'h01_0000, 18'h1_0000, 24'h01_0000, 18'h1_0000, 1'b0));
        rows.push_back(cell_row(32'hFFFF_F000, 24'h00_8000, 18'h0_6666, 24'h05_0000,
                                18'h0_8000, 1'b0));
        rows.push_back(cell_row(32'h0064_0000, 24'h00_4CCD, 18'h0_6666, 24'h04_0000,
                                18'h0_8000, 1'b0));
        rows.push_back(cell_row(32'h0000_0001, 24'hFF_FFFF, 18'h3_FFFF, 24'h00_0001,
                                18'h0, 1'b0));
        rows.push_back(cell_row(32'h5555_5555, 24'hAA_AAAA, 18'h2_AAAA, 24'h55_5555,
                                18'h1_5555, 1'b0));
        rows.push_back(cell_row(32'hAAAA_AAAA, 24'h55_5555, 18'h1_5555, 24'hAA_AAAA,
                                18'h2_AAAA, 1'b1));
        rows.push_back(cell_row(32'h0, 24'hFF_FFFF, 18'h0, 24'hFF_FFFF, 18'h0, 1'b0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            r = rows[i];
            send_cell(r.c, r.miss);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (geom_pending.size() != 0) @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (geom_pending.size() != 0) @(posedge aclk);
                stall_enable = 1'b0;
            end
            if (i == N_RANDOM / 2 + 200) stall_enable = 1'b1;
            if (i >= N_RANDOM / 2 && i < N_RANDOM / 2 + 200) begin
                s_tdata <= {4'b0, random_cell()};
                s_tuser <= ($urandom_range(0, 15) == 0);
                s_tvalid <= 1'b1;
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                n_cells++;
            end else begin
                send_cell(random_cell(), $urandom_range(0, 15) == 0);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        s_xfer_done = 1'b1;
        while (geom_pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d cells including directed extremes, checked %0d results",
                 n_cells, n_results);
        $display("under random source gaps, sink stalls and one back-to-back burst.");
        if (errors == 0 && geom_pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> files.f
design/hgpl_pkg.sv
design/hgpl_log.sv
design/hgpl_div.sv
design/hydraulic_geometry_power_law_core.sv
test/hydraulic_geometry_power_law_core_tb.sv
